/* sv/lruhw_pkg.sv */
// Shared widths, reset values and result codes for the LRU cache with hot window.
package lruhw_pkg;

    localparam int KEY_W          = 24;
    localparam int TICK_W         = 32;
    localparam int HOT_W          = 16;
    localparam int STATUS_W       = 3;
    localparam int SLOT_W         = 5;
    localparam int PORT_HANDLE_W  = 16;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [HOT_W-1:0] HOT_WINDOW_RESET = 16'd64;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FETCH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

    // Outcome of one full scan over the entry memory.
    typedef struct packed {
        logic hit;          // some valid entry carries the key
        logic victim_ok;    // some slot is replaceable
        logic victim_used;  // the chosen slot holds a valid entry
    } scan_flags_t;

endpackage

/* sv/lruhw_mem.sv */
// Entry memory: one write port, one registered read port.
module lruhw_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lruhw_scan.sv */
// Scan accumulator: first key match, first empty slot and oldest replaceable entry.
module lruhw_scan #(
    parameter int NUM_ENTRIES = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic                                       rd_valid,
    input  logic [$clog2(NUM_ENTRIES)-1:0]             rd_idx,
    input  logic [lruhw_pkg::KEY_W+HANDLE_BITS+lruhw_pkg::TICK_W-1:0] rd_word,
    input  logic                                       ent_valid,
    input  logic [lruhw_pkg::KEY_W-1:0]                key_q,
    input  logic [lruhw_pkg::TICK_W-1:0]               tick_q,
    input  logic [lruhw_pkg::HOT_W-1:0]                hot_window,
    output lruhw_pkg::scan_flags_t                     flags,
    output logic [$clog2(NUM_ENTRIES)-1:0]             hit_idx,
    output logic [HANDLE_BITS-1:0]                     hit_handle,
    output logic [$clog2(NUM_ENTRIES)-1:0]             victim_idx,
    output logic [HANDLE_BITS-1:0]                     victim_handle
);
    import lruhw_pkg::*;

    localparam int IDX_W = $clog2(NUM_ENTRIES);

    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [TICK_W-1:0]      rd_last;
    logic [TICK_W-1:0]      free_at;
    logic                   cold;

    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [HANDLE_BITS-1:0] hit_handle_reg, hit_handle_next;
    logic                   empty_reg, empty_next;
    logic [IDX_W-1:0]       empty_idx_reg, empty_idx_next;
    logic                   best_reg, best_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;
    logic [TICK_W-1:0]      oldest_reg, oldest_next;

    assign {rd_key, rd_handle, rd_last} = rd_word;
    assign free_at = rd_last + TICK_W'(hot_window);
    assign cold    = (free_at <= tick_q);

    always_comb
    begin
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_handle_next  = hit_handle_reg;
        empty_next       = empty_reg;
        empty_idx_next   = empty_idx_reg;
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        best_handle_next = best_handle_reg;
        oldest_next      = oldest_reg;
        if (start)
        begin
            hit_next   = 1'b0;
            empty_next = 1'b0;
            best_next  = 1'b0;
        end
        else if (rd_valid)
        begin
            // keep the lowest matching slot
            if (ent_valid && !hit_reg && rd_key == key_q)
            begin
                hit_next        = 1'b1;
                hit_idx_next    = rd_idx;
                hit_handle_next = rd_handle;
            end
            if (!ent_valid)
            begin
                if (!empty_reg)
                begin
                    empty_next     = 1'b1;
                    empty_idx_next = rd_idx;
                end
            end
            else if (cold && (!best_reg || rd_last < oldest_reg))
            begin
                best_next        = 1'b1;
                best_idx_next    = rd_idx;
                best_handle_next = rd_handle;
                oldest_next      = rd_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
            best_reg  <= 1'b0;
        end
        else
        begin
            hit_reg   <= hit_next;
            empty_reg <= empty_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg     <= hit_idx_next;
        hit_handle_reg  <= hit_handle_next;
        empty_idx_reg   <= empty_idx_next;
        best_idx_reg    <= best_idx_next;
        best_handle_reg <= best_handle_next;
        oldest_reg      <= oldest_next;
    end

    // an empty slot always wins over an aged one
    assign flags.hit         = hit_reg;
    assign flags.victim_ok   = empty_reg || best_reg;
    assign flags.victim_used = !empty_reg && best_reg;
    assign hit_idx           = hit_idx_reg;
    assign hit_handle        = hit_handle_reg;
    assign victim_idx        = empty_reg ? empty_idx_reg : best_idx_reg;
    assign victim_handle     = best_handle_reg;

endmodule

/* sv/lru_cache_with_hot_window_unit.sv */
// Each accepted transaction runs through S_SCAN, S_WAIT and S_DONE before its result shows on rsp_valid.
// Transactions do not overlap: req_stall holds off a new one until S_IDLE, since the
//   single read port of the entry memory is swept once per transaction.
// Reset: all entries invalid, tick and generation zero, hot_window 64; no clearing pass,
//   the block can take a transaction straight after reset.
module lru_cache_with_hot_window_unit #(
    parameter int NUM_ENTRIES = lruhw_pkg::NUM_ENTRIES_DEF,
    parameter int HANDLE_BITS = lruhw_pkg::HANDLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  hot_window_we,
    input  logic [lruhw_pkg::HOT_W-1:0]           hot_window,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic                                  kind,
    input  logic [lruhw_pkg::KEY_W-1:0]           key,
    input  logic [lruhw_pkg::PORT_HANDLE_W-1:0]   handle,
    // response channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [lruhw_pkg::STATUS_W-1:0]        status,
    output logic [lruhw_pkg::SLOT_W-1:0]          slot,
    output logic [lruhw_pkg::PORT_HANDLE_W-1:0]   entry_handle,
    output logic                                  evicted,
    output logic [lruhw_pkg::PORT_HANDLE_W-1:0]   evicted_handle,
    output logic [lruhw_pkg::TICK_W-1:0]          generation
);
    import lruhw_pkg::*;

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int WORD_W = KEY_W + HANDLE_BITS + TICK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // control and architectural state
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [TICK_W-1:0]      gen_reg, gen_next;
    logic [HOT_W-1:0]       hot_reg, hot_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;

    // captured transaction
    logic                   kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;

    // response register
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [PORT_HANDLE_W-1:0] ent_handle_reg, ent_handle_next;
    logic                     evicted_reg, evicted_next;
    logic [PORT_HANDLE_W-1:0] ev_handle_reg, ev_handle_next;

    // memory and scan hookup
    logic                   accept;
    logic                   rsp_free;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [WORD_W-1:0]      mem_rdata;
    scan_flags_t            flags;
    logic [IDX_W-1:0]       hit_idx;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic [IDX_W-1:0]       victim_idx;
    logic [HANDLE_BITS-1:0] victim_handle;

    assign accept   = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign mem_re   = (state_reg == S_SCAN);

    lruhw_mem #(
        .DEPTH (NUM_ENTRIES),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    lruhw_scan #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .rd_valid      (rd_valid_reg),
        .rd_idx        (rd_idx_reg),
        .rd_word       (mem_rdata),
        .ent_valid     (valid_reg[rd_idx_reg]),
        .key_q         (key_reg),
        .tick_q        (tick_reg),
        .hot_window    (hot_reg),
        .flags         (flags),
        .hit_idx       (hit_idx),
        .hit_handle    (hit_handle),
        .victim_idx    (victim_idx),
        .victim_handle (victim_handle)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        tick_next       = tick_reg;
        gen_next        = gen_reg;
        hot_next        = hot_reg;
        addr_next       = addr_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = addr_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        status_next     = status_reg;
        slot_next       = slot_reg;
        ent_handle_next = ent_handle_reg;
        evicted_next    = evicted_reg;
        ev_handle_next  = ev_handle_reg;
        mem_we          = 1'b0;
        mem_waddr       = hit_idx;
        mem_wdata       = {key_reg, hit_handle, tick_reg};
        req_stall       = (state_reg != S_IDLE);

        if (hot_window_we)
        begin
            hot_next = hot_window;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    // capture the transaction; a lookup advances the tick up front
                    kind_next   = kind;
                    key_next    = key;
                    handle_next = HANDLE_BITS'(handle);
                    addr_next   = '0;
                    if (kind == KIND_LOOKUP)
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle; data comes back from the registered read port on the next cycle
                rd_valid_next = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                // last entry is being folded into the scan this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    slot_next       = '0;
                    ent_handle_next = '0;
                    evicted_next    = 1'b0;
                    ev_handle_next  = '0;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        if (flags.hit)
                        begin
                            // refresh last use of the hit entry
                            mem_we          = 1'b1;
                            status_next     = ST_HIT;
                            slot_next       = SLOT_W'(hit_idx);
                            ent_handle_next = PORT_HANDLE_W'(hit_handle);
                        end
                        else if (flags.victim_ok)
                        begin
                            status_next = ST_FETCH;
                        end
                        else
                        begin
                            status_next = ST_PINNED;
                        end
                    end
                    else if (flags.victim_ok)
                    begin
                        mem_we                 = 1'b1;
                        mem_waddr              = victim_idx;
                        mem_wdata              = {key_reg, handle_reg, tick_reg};
                        valid_next[victim_idx] = 1'b1;
                        gen_next               = gen_reg + 1'b1;
                        status_next            = ST_INSERTED;
                        slot_next              = SLOT_W'(victim_idx);
                        if (flags.victim_used)
                        begin
                            evicted_next   = 1'b1;
                            ev_handle_next = PORT_HANDLE_W'(victim_handle);
                        end
                    end
                    else
                    begin
                        status_next = ST_DROPPED;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            tick_reg       <= '0;
            gen_reg        <= '0;
            hot_reg        <= HOT_WINDOW_RESET;
            addr_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= ST_HIT;
            slot_reg       <= '0;
            ent_handle_reg <= '0;
            evicted_reg    <= 1'b0;
            ev_handle_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            tick_reg       <= tick_next;
            gen_reg        <= gen_next;
            hot_reg        <= hot_next;
            addr_reg       <= addr_next;
            rd_valid_reg   <= rd_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            ent_handle_reg <= ent_handle_next;
            evicted_reg    <= evicted_next;
            ev_handle_reg  <= ev_handle_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign slot           = slot_reg;
    assign entry_handle   = ent_handle_reg;
    assign evicted        = evicted_reg;
    assign evicted_handle = ev_handle_reg;
    assign generation     = gen_reg;

endmodule
